>>> sv/pfb_pkg.sv
// Shared types and constants for the page framebuffer blit/refresh block.
package pfb_pkg;

  // Default geometry: 128 columns by 8 pages of 8 rows
  localparam int COLUMNS_DEF = 128;
  localparam int PAGES_DEF   = 8;

  localparam int CMD_W = 3;

  // Command codes on the item channel
  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR   = 3'd0,
    CMD_PLOT    = 3'd1,
    CMD_BLIT    = 3'd2,
    CMD_BYTE    = 3'd3,
    CMD_REFRESH = 3'd4
  } cmd_t;

  // Panel command bytes sent at the head of each page
  localparam logic [7:0] PAGE_CMD_BASE = 8'hB0;
  localparam logic [7:0] HIGH_COL_CMD  = 8'h10;
  localparam logic [3:0] LOW_COL_RESET = 4'h2;

  // Number of command bytes ahead of each page's data
  localparam int PAGE_HDR_LEN = 3;

endpackage

>>> sv/pfb_in_if.sv
// Item channel: draw and refresh commands.
interface pfb_in_if import pfb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic               color;
  logic [7:0]         blit_width;
  logic [7:0]         blit_height;
  logic [7:0]         column_bits;

  modport source (output valid, cmd, pos_x, pos_y, color, blit_width, blit_height,
                  column_bits, input ready);
  modport sink (input valid, cmd, pos_x, pos_y, color, blit_width, blit_height,
                column_bits, output ready);
endinterface

>>> sv/pfb_out_if.sv
// Result channel: panel stream bytes.
interface pfb_out_if ();
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  logic       is_command;
  logic       page_done;
  logic       frame_done;

  modport source (output valid, stream_byte, is_command, page_done, frame_done,
                  input ready);
  modport sink (input valid, stream_byte, is_command, page_done, frame_done,
                output ready);
endinterface

>>> sv/page_framebuffer_blit_refresh.sv
// Page framebuffer with pixel plot, bitmap blit and panel refresh stream.
//
//   channel  | dir | beat contents
//   ---------+-----+---------------------------------------------------------
//   item     | in  | cmd, pos_x, pos_y, color, blit_width, blit_height, column_bits
//   stream   | out | stream_byte, is_command, page_done, frame_done
//   cfg      | in  | cfg_wr_en, cfg_wr_data (low column code)
//
// Steps per item: blit start and unknown commands accept only; plot accept, read,
// write, or accept only when off screen; blit byte accept, read, write, plus a
// second read and write when the column straddles two pages, or accept only
// when nothing lands in the store; refresh accept, read, put, plus any wait for
// the output register; clear the accept, then one store byte written per cycle
// over the single write port. After reset the sweep runs before item.ready rises.
// A held stream beat does not stop the item side; only a refresh waits on it.
module page_framebuffer_blit_refresh import pfb_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int PAGES   = PAGES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_wr_data,
  pfb_in_if.sink     item,
  pfb_out_if.source  stream
);

  localparam int STORE  = COLUMNS * PAGES;
  localparam int ADDR_W = $clog2(STORE);
  localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int OFF_W  = $clog2(COLUMNS + PAGE_HDR_LEN);
  localparam int ROWS   = PAGES * 8;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_RD, S_WR, S_REF_RD, S_REF_PUT
  } state_t;

  state_t state;

  // Frame store and its ports
  logic [7:0]        mem [STORE];
  logic [7:0]        rd_data;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  logic [7:0]        mem_wdata;

  // Read-modify-write operation and the queued second byte of a blit column
  logic [ADDR_W-1:0] clr_addr;
  logic [ADDR_W-1:0] op_addr;
  logic [7:0]        op_set;
  logic [7:0]        op_clr;
  logic              pend_valid;
  logic [ADDR_W-1:0] pend_addr;
  logic [7:0]        pend_set;

  // Blit window and cursor
  logic signed [15:0] blit_left;
  logic signed [16:0] blit_right;
  logic signed [16:0] blit_bottom;
  logic signed [16:0] cursor_col;
  logic signed [16:0] cursor_row;

  // Refresh position as page, offset in page and store address
  logic [PAGE_W-1:0] ref_page;
  logic [OFF_W-1:0]  ref_off;
  logic [ADDR_W-1:0] ref_addr;
  logic [3:0]        low_column_code;

  // Output register
  logic       ovalid;
  logic [7:0] obyte;
  logic       ocmd;
  logic       opdone;
  logic       ofdone;

  logic fire;
  assign fire = item.valid && item.ready;
  assign item.ready = (state == S_IDLE);

  // Plot decode
  logic              plot_ok;
  logic [PAGE_W-1:0] plot_page;
  logic [COL_W-1:0]  plot_col;
  logic [ADDR_W-1:0] plot_addr;
  logic [7:0]        plot_mask;

  always_comb begin
    plot_ok   = (item.pos_x >= 16'sd0) && (item.pos_x < $signed(16'(COLUMNS)))
             && (item.pos_y >= 16'sd0) && (item.pos_y < $signed(16'(ROWS)));
    plot_page = item.pos_y[PAGE_W+2:3];
    plot_col  = item.pos_x[COL_W-1:0];
    plot_addr = ADDR_W'(plot_page * COLUMNS + plot_col);
    plot_mask = 8'd1 << item.pos_y[2:0];
  end

  // Blit byte decode: column may cover two pages
  logic               bb_active;
  logic signed [16:0] col_next;
  logic               bb_col_ok;
  logic signed [16:0] band_lo;
  logic signed [16:0] band_hi;
  logic               lo_ok;
  logic               hi_ok;
  logic [15:0]        spread;
  logic [COL_W-1:0]   bb_col;
  logic [ADDR_W-1:0]  lo_addr;
  logic [ADDR_W-1:0]  hi_addr;

  always_comb begin
    bb_active = (cursor_col < blit_right) && (cursor_row < blit_bottom);
    col_next  = cursor_col + 17'sd1;
    bb_col_ok = (cursor_col >= 17'sd0) && (cursor_col < $signed(17'(COLUMNS)));
    band_lo   = cursor_row >>> 3;
    band_hi   = band_lo + 17'sd1;
    lo_ok     = (band_lo >= 17'sd0) && (band_lo < $signed(17'(PAGES)));
    hi_ok     = (cursor_row[2:0] != 3'd0) && (band_hi >= 17'sd0)
             && (band_hi < $signed(17'(PAGES)));
    spread    = {8'd0, item.column_bits} << cursor_row[2:0];
    bb_col    = cursor_col[COL_W-1:0];
    lo_addr   = ADDR_W'(band_lo[PAGE_W-1:0] * COLUMNS + bb_col);
    hi_addr   = ADDR_W'(band_hi[PAGE_W-1:0] * COLUMNS + bb_col);
  end

  // Refresh byte selection
  logic       ref_is_cmd;
  logic       ref_pdone;
  logic       ref_fdone;
  logic [7:0] ref_byte;
  logic       out_free;

  always_comb begin
    ref_is_cmd = ref_off < OFF_W'(PAGE_HDR_LEN);
    ref_pdone  = ref_off == OFF_W'(COLUMNS + PAGE_HDR_LEN - 1);
    ref_fdone  = ref_pdone && (ref_page == PAGE_W'(PAGES - 1));
    case (ref_off)
      OFF_W'(0): ref_byte = PAGE_CMD_BASE + 8'(ref_page);
      OFF_W'(1): ref_byte = {4'd0, low_column_code};
      OFF_W'(2): ref_byte = HIGH_COL_CMD;
      default:   ref_byte = rd_data;
    endcase
    out_free = !ovalid || stream.ready;
  end

  // Store port control; the merge is the one shared modify unit
  // Read address stays on the refresh byte while its beat waits
  always_comb begin
    mem_we    = (state == S_CLEAR) || (state == S_WR);
    mem_waddr = (state == S_CLEAR) ? clr_addr : op_addr;
    mem_wdata = (state == S_CLEAR) ? 8'd0 : ((rd_data & ~op_clr) | op_set);
    mem_raddr = ((state == S_REF_RD) || (state == S_REF_PUT)) ? ref_addr : op_addr;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  // Sequencer, blit state, refresh counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLEAR;
      clr_addr        <= '0;
      pend_valid      <= 1'b0;
      blit_left       <= '0;
      blit_right      <= '0;
      blit_bottom     <= '0;
      cursor_col      <= '0;
      cursor_row      <= '0;
      ref_page        <= '0;
      ref_off         <= '0;
      ref_addr        <= '0;
      low_column_code <= LOW_COL_RESET;
      ovalid          <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        low_column_code <= cfg_wr_data;
      end
      // Drop a taken beat; in S_REF_PUT the load below covers it
      if (ovalid && stream.ready && (state != S_REF_PUT)) begin
        ovalid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(STORE - 1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (fire) begin
            case (item.cmd)
              CMD_CLEAR: begin
                clr_addr <= '0;
                state    <= S_CLEAR;
              end
              CMD_PLOT: begin
                op_addr    <= plot_addr;
                op_set     <= item.color ? plot_mask : 8'd0;
                op_clr     <= item.color ? 8'd0 : plot_mask;
                pend_valid <= 1'b0;
                if (plot_ok) begin
                  state <= S_RD;
                end
              end
              CMD_BLIT: begin
                blit_left   <= item.pos_x;
                blit_right  <= 17'(item.pos_x) + $signed({9'd0, item.blit_width});
                blit_bottom <= 17'(item.pos_y) + $signed({9'd0, item.blit_height});
                cursor_col  <= 17'(item.pos_x);
                cursor_row  <= 17'(item.pos_y);
              end
              CMD_BYTE: begin
                if (bb_active) begin
                  if (col_next >= blit_right) begin
                    cursor_col <= 17'(blit_left);
                    cursor_row <= cursor_row + 17'sd8;
                  end else begin
                    cursor_col <= col_next;
                  end
                  op_clr <= 8'd0;
                  if (bb_col_ok && lo_ok) begin
                    op_addr    <= lo_addr;
                    op_set     <= spread[7:0];
                    pend_valid <= hi_ok;
                    pend_addr  <= hi_addr;
                    pend_set   <= spread[15:8];
                    state      <= S_RD;
                  end else if (bb_col_ok && hi_ok) begin
                    op_addr    <= hi_addr;
                    op_set     <= spread[15:8];
                    pend_valid <= 1'b0;
                    state      <= S_RD;
                  end
                end
              end
              CMD_REFRESH: begin
                state <= S_REF_RD;
              end
              default: begin
              end
            endcase
          end
        end

        S_RD: begin
          state <= S_WR;
        end

        S_WR: begin
          if (pend_valid) begin
            op_addr    <= pend_addr;
            op_set     <= pend_set;
            pend_valid <= 1'b0;
            state      <= S_RD;
          end else begin
            state <= S_IDLE;
          end
        end

        S_REF_RD: begin
          state <= S_REF_PUT;
        end

        S_REF_PUT: begin
          if (out_free) begin
            ovalid <= 1'b1;
            obyte  <= ref_byte;
            ocmd   <= ref_is_cmd;
            opdone <= ref_pdone;
            ofdone <= ref_fdone;
            if (ref_pdone) begin
              ref_off <= '0;
              if (ref_fdone) begin
                ref_page <= '0;
                ref_addr <= '0;
              end else begin
                ref_page <= ref_page + PAGE_W'(1);
                ref_addr <= ref_addr + ADDR_W'(1);
              end
            end else begin
              ref_off <= ref_off + OFF_W'(1);
              if (!ref_is_cmd) begin
                ref_addr <= ref_addr + ADDR_W'(1);
              end
            end
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign stream.valid       = ovalid;
  assign stream.stream_byte = obyte;
  assign stream.is_command  = ocmd;
  assign stream.page_done   = opdone;
  assign stream.frame_done  = ofdone;

  // Offset within a page never runs past the last data byte
  a_off_range: assert property (@(posedge clk) disable iff (rst)
    ref_off <= OFF_W'(COLUMNS + PAGE_HDR_LEN - 1))
    else $error("refresh offset out of range");

  // Start of frame always points at store address zero
  a_frame_start: assert property (@(posedge clk) disable iff (rst)
    (ref_off == '0 && ref_page == '0) |-> ref_addr == '0)
    else $error("refresh address out of step with page/offset");

  // A refresh byte waits while the previous beat is held
  a_ref_wait: assert property (@(posedge clk) disable iff (rst)
    (state == S_REF_PUT && ovalid && !stream.ready) |=> state == S_REF_PUT)
    else $error("refresh byte loaded over a held beat");

  // A clear command always starts the sweep
  a_clear_sweep: assert property (@(posedge clk) disable iff (rst)
    (fire && item.cmd == CMD_CLEAR) |=> (state == S_CLEAR && clr_addr == '0))
    else $error("clear command did not start sweep");

endmodule
